// ===== rtl/cfce_pkg.sv =====
// Shared constants, types and CRC byte-update functions for the command frame CRC encoder.
// No dependencies; used by every module under rtl/.
package cfce_pkg;

  localparam int unsigned MaxBytes = 7;                 // bytes one input beat can produce
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  localparam logic [7:0]  Preamble0 = 8'h55;
  localparam logic [7:0]  Preamble1 = 8'hAA;
  localparam int unsigned JobBit    = 5;                // header bit selecting a job frame
  localparam logic [7:0]  JobLenAdd = 8'd4;
  localparam logic [7:0]  CmdLenAdd = 8'd3;

  localparam logic [15:0] Crc16Poly = 16'h1021;
  localparam logic [15:0] Crc16Init = 16'hFFFF;
  localparam logic [4:0]  Crc5Poly  = 5'h05;
  localparam logic [4:0]  Crc5Init  = 5'h1F;

  typedef logic [MaxBytes-1:0][7:0] byte_vec_t;

  // Bytes produced by one input beat, handed from framer to serialiser.
  typedef struct packed {
    byte_vec_t       bytes;
    logic [IdxW-1:0] last_idx;   // index of the final byte in this group
    logic            ends;       // final byte closes a frame
  } result_t;

  // CRC-16/CCITT-FALSE, MSB first, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ Crc16Poly) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // 5-bit CRC, poly 0x05, MSB first, one byte.
  function automatic logic [4:0] crc5_byte(input logic [4:0] c, input logic [7:0] b);
    logic [4:0] r;
    logic       fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = b[i] ^ r[4];
      r  = {r[3:0], 1'b0};
      if (fb) begin
        r = r ^ Crc5Poly;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/cfce_framer.sv =====
// Frame builder: turns one registered input beat into its group of output bytes
// and keeps the running CRC state. Depends on cfce_pkg.
module cfce_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,     // group moves into the serialiser
  input  logic [7:0]          header_i,
  input  logic [7:0]          plen_i,
  input  logic [7:0]          data_i,
  input  logic                first_i,
  input  logic                last_i,
  output cfce_pkg::result_t   result_o
);

  logic [15:0] crc16_q, crc16_d;
  logic [4:0]  crc5_q, crc5_d;
  logic        job_q, job_d;

  logic [7:0]  len_byte;
  logic [15:0] c16_pre;
  logic [4:0]  c5_pre;
  logic [cfce_pkg::IdxW-1:0] base;
  cfce_pkg::byte_vec_t       bytes;
  logic [cfce_pkg::IdxW-1:0] last_idx;

  always_comb begin
    job_d    = first_i ? header_i[cfce_pkg::JobBit] : job_q;
    len_byte = plen_i + (job_d ? cfce_pkg::JobLenAdd : cfce_pkg::CmdLenAdd);

    // header and length only enter the CRC on the opening beat
    if (first_i) begin
      c16_pre = cfce_pkg::crc16_byte(cfce_pkg::crc16_byte(cfce_pkg::Crc16Init, header_i),
                                     len_byte);
      c5_pre  = cfce_pkg::crc5_byte(cfce_pkg::crc5_byte(cfce_pkg::Crc5Init, header_i),
                                    len_byte);
    end else begin
      c16_pre = crc16_q;
      c5_pre  = crc5_q;
    end
    crc16_d = cfce_pkg::crc16_byte(c16_pre, data_i);
    crc5_d  = cfce_pkg::crc5_byte(c5_pre, data_i);

    bytes = '0;
    base  = '0;
    if (first_i) begin
      bytes[0] = cfce_pkg::Preamble0;
      bytes[1] = cfce_pkg::Preamble1;
      bytes[2] = header_i;
      bytes[3] = len_byte;
      base     = cfce_pkg::IdxW'(4);
    end
    bytes[base] = data_i;
    last_idx    = base;
    if (last_i) begin
      if (job_d) begin
        bytes[base + cfce_pkg::IdxW'(1)] = crc16_d[15:8];
        bytes[base + cfce_pkg::IdxW'(2)] = crc16_d[7:0];
        last_idx                         = base + cfce_pkg::IdxW'(2);
      end else begin
        bytes[base + cfce_pkg::IdxW'(1)] = {3'b000, crc5_d};
        last_idx                         = base + cfce_pkg::IdxW'(1);
      end
    end
  end

  assign result_o.bytes    = bytes;
  assign result_o.last_idx = last_idx;
  assign result_o.ends     = last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc16_q <= cfce_pkg::Crc16Init;
      crc5_q  <= cfce_pkg::Crc5Init;
      job_q   <= 1'b0;
    end else if (load_i) begin
      job_q   <= job_d;
      crc16_q <= last_i ? cfce_pkg::Crc16Init : crc16_d;
      crc5_q  <= last_i ? cfce_pkg::Crc5Init : crc5_d;
    end
  end

endmodule

// ===== rtl/cfce_serialiser.sv =====
// Result register: holds one group of up to seven bytes and sends them a beat at a time.
// Depends on cfce_pkg.
module cfce_serialiser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_valid_i,
  input  cfce_pkg::result_t result_i,
  output logic              load_ready_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] wire_byte
  output logic              m_axis_tlast    // frame_end
);

  cfce_pkg::byte_vec_t       buf_q;
  logic [cfce_pkg::IdxW-1:0] last_idx_q;
  logic [cfce_pkg::IdxW-1:0] idx_q;
  logic                      ends_q;
  logic                      valid_q;
  logic                      at_last;
  logic                      beat;

  assign at_last      = (idx_q == last_idx_q);
  assign beat         = valid_q && m_axis_tready;
  // next group may load while the final byte of this one goes out
  assign load_ready_o = !valid_q || (beat && at_last);

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = buf_q[idx_q];
  assign m_axis_tlast  = ends_q && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_valid_i && load_ready_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (beat) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + cfce_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ready_o) begin
      buf_q      <= result_i.bytes;
      last_idx_q <= result_i.last_idx;
      ends_q     <= result_i.ends;
    end
  end

endmodule

// ===== rtl/command_frame_crc_encoder.sv =====
// Command frame CRC encoder. Each payload beat is taken into an input register, expanded
// in one pass into its bytes (preamble 0x55 0xAA, header and length on a first beat, the
// payload byte, and the CRC trailer on a last beat) and parked in a result register that
// sends one byte per output beat. The byte-wide output port sets the rate: a middle beat
// yields one byte, a first beat five, and a last beat one more for a command frame (CRC5)
// or two more for a job frame (CRC-16), so a lone one-byte frame yields six or seven bytes.
// While a group drains the input register takes one more beat and then holds it, with
// s_axis_tready low, until the final byte of the current group goes out; it moves on in
// that same cycle. With both sides free, an accepted input beat passes through the input
// register and then the result register before the first byte of its group is offered.
module command_frame_crc_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] header_byte, [15:8] payload_length,
                                      // [23:16] payload_byte
  input  logic        s_axis_tuser,   // first_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] wire_byte
  output logic        m_axis_tlast    // frame_end
);

  logic        in_valid_q;
  logic [7:0]  header_q, plen_q, data_q;
  logic        first_q, last_q;
  logic        load_ready;
  logic        move;
  cfce_pkg::result_t result;

  assign move          = in_valid_q && load_ready;
  assign s_axis_tready = !in_valid_q || load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      header_q <= s_axis_tdata[7:0];
      plen_q   <= s_axis_tdata[15:8];
      data_q   <= s_axis_tdata[23:16];
      first_q  <= s_axis_tuser;
      last_q   <= s_axis_tlast;
    end
  end

  cfce_framer u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (move),
    .header_i (header_q),
    .plen_i   (plen_q),
    .data_i   (data_q),
    .first_i  (first_q),
    .last_i   (last_q),
    .result_o (result)
  );

  cfce_serialiser u_serialiser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_valid_i  (in_valid_q),
    .result_i      (result),
    .load_ready_o  (load_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
